/* design/mer_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Widths, microcode field encodings, control word and status types shared by
// the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int RADIUS_BITS  = 10;
    localparam int COORD_BITS   = 12;

    localparam int XY_W         = RADIUS_BITS + 2;
    localparam int SQ_W         = 2 * RADIUS_BITS;
    localparam int SUM2_W       = SQ_W + 1;
    localparam int MUL_W        = 2 * RADIUS_BITS + 3;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DEC_W        = PROD_W + 2;
    localparam int OUT_W        = COORD_BITS + 1;
    localparam int SUM_W        = ((OUT_W > XY_W) ? OUT_W : XY_W) + 1;
    localparam int IN_FIELDS_W  = 2 * COORD_BITS + 2 * RADIUS_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 8 * OUT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int PC_W         = 5;

    // microcode addresses
    localparam logic [PC_W-1:0] UA_IDLE = PC_W'(0);
    localparam logic [PC_W-1:0] UA_S0   = PC_W'(1);
    localparam logic [PC_W-1:0] UA_S1   = PC_W'(2);
    localparam logic [PC_W-1:0] UA_S2   = PC_W'(3);
    localparam logic [PC_W-1:0] UA_S3   = PC_W'(4);
    localparam logic [PC_W-1:0] UA_S4   = PC_W'(5);
    localparam logic [PC_W-1:0] UA_EM0  = PC_W'(6);
    localparam logic [PC_W-1:0] UA_ZRO  = PC_W'(7);
    localparam logic [PC_W-1:0] UA_EM1  = PC_W'(8);
    localparam logic [PC_W-1:0] UA_T0   = PC_W'(9);
    localparam logic [PC_W-1:0] UA_T1   = PC_W'(10);
    localparam logic [PC_W-1:0] UA_T2   = PC_W'(11);
    localparam logic [PC_W-1:0] UA_T3   = PC_W'(12);
    localparam logic [PC_W-1:0] UA_T4   = PC_W'(13);
    localparam logic [PC_W-1:0] UA_E0   = PC_W'(14);
    localparam logic [PC_W-1:0] UA_E1   = PC_W'(15);
    localparam logic [PC_W-1:0] UA_C0   = PC_W'(16);
    localparam logic [PC_W-1:0] UA_C1   = PC_W'(17);
    localparam logic [PC_W-1:0] UA_C2   = PC_W'(18);
    localparam logic [PC_W-1:0] UA_U0   = PC_W'(19);
    localparam logic [PC_W-1:0] UA_U1   = PC_W'(20);
    localparam logic [PC_W-1:0] UA_U2   = PC_W'(21);

    localparam logic OP_START = 1'b0;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_A2A2,
        MUL_A2B,
        MUL_B2A,
        MUL_XX,
        MUL_TS,
        MUL_B2X,
        MUL_A2Y,
        MUL_A2YP,
        MUL_B2XM
    } mul_op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SUM,
        ACT_INIT1,
        ACT_ZERO,
        ACT_ENTER2,
        ACT_INIT2,
        ACT_UPD1,
        ACT_UPD2
    } act_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_JUMP,
        BR_ZERO,
        BR_OUTSIDE,
        BR_DISPATCH
    } br_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_FIT
    } last_t;

    typedef struct packed {
        logic            take;
        logic            emit;
        last_t           last_sel;
        mul_op_t         mul;
        act_t            act;
        br_t             br;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic zero_rad;
        logic fits;
        logic slot_free;
        logic active;
        logic region_two;
    } status_t;

endpackage
`default_nettype wire

/* design/mer_ucode_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mer_ucode_rom
// Microprogram store: one control word per step address.
// ----------------------------------------------------------------------------
module mer_ucode_rom (
    input  wire logic [mer_pkg::PC_W-1:0] addr,
    output mer_pkg::ctrl_t                word
);
    import mer_pkg::*;

    always_comb
    begin
        word          = '0;
        word.take     = 1'b0;
        word.emit     = 1'b0;
        word.last_sel = LAST_NO;
        word.mul      = MUL_NONE;
        word.act      = ACT_NONE;
        word.br       = BR_NEXT;
        word.target   = UA_IDLE;
        case (addr)
            UA_IDLE:
            begin
                word.take = 1'b1;
                word.br   = BR_DISPATCH;
            end
            // start: squares, a^4, a2+b2, then the region one decision
            UA_S0:
            begin
                word.mul    = MUL_AA;
                word.br     = BR_ZERO;
                word.target = UA_ZRO;
            end
            UA_S1: word.mul = MUL_BB;
            UA_S2:
            begin
                word.mul = MUL_A2A2;
                word.act = ACT_SUM;
            end
            UA_S3: word.mul = MUL_A2B;
            UA_S4: word.act = ACT_INIT1;
            UA_EM0:
            begin
                word.emit     = 1'b1;
                word.last_sel = LAST_NO;
                word.br       = BR_JUMP;
                word.target   = UA_IDLE;
            end
            UA_ZRO: word.act = ACT_ZERO;
            UA_EM1:
            begin
                word.emit     = 1'b1;
                word.last_sel = LAST_YES;
                word.br       = BR_JUMP;
                word.target   = UA_IDLE;
            end
            // region one step
            UA_T0: word.mul = MUL_XX;
            UA_T1: word.mul = MUL_TS;
            UA_T2:
            begin
                word.mul    = MUL_B2X;
                word.br     = BR_OUTSIDE;
                word.target = UA_E0;
            end
            UA_T3: word.mul = MUL_A2Y;
            UA_T4:
            begin
                word.act    = ACT_UPD1;
                word.br     = BR_JUMP;
                word.target = UA_EM0;
            end
            // switch to region two
            UA_E0:
            begin
                word.mul = MUL_B2A;
                word.act = ACT_ENTER2;
            end
            UA_E1: word.act = ACT_INIT2;
            // boundary check, emit with last flag
            UA_C0: word.mul = MUL_XX;
            UA_C1: word.mul = MUL_TS;
            UA_C2:
            begin
                word.emit     = 1'b1;
                word.last_sel = LAST_FIT;
                word.br       = BR_JUMP;
                word.target   = UA_IDLE;
            end
            // region two step
            UA_U0: word.mul = MUL_A2YP;
            UA_U1: word.mul = MUL_B2XM;
            UA_U2:
            begin
                word.act    = ACT_UPD2;
                word.br     = BR_JUMP;
                word.target = UA_C0;
            end
            default:
            begin
                word.br     = BR_JUMP;
                word.target = UA_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/mer_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mer_sequencer
// Step counter with conditional jumps and entry dispatch over the microcode.
// ----------------------------------------------------------------------------
module mer_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_op,
    input  wire mer_pkg::status_t status,
    output mer_pkg::ctrl_t       word
);
    import mer_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;

    mer_ucode_rom u_rom (
        .addr (pc_reg),
        .word (word)
    );

    assign pc_inc = pc_reg + PC_W'(1);

    always_comb
    begin
        pc_next = pc_inc;
        case (word.br)
            BR_NEXT:    pc_next = pc_inc;
            BR_JUMP:    pc_next = word.target;
            BR_ZERO:    pc_next = status.zero_rad ? word.target : pc_inc;
            BR_OUTSIDE: pc_next = status.fits ? pc_inc : word.target;
            BR_DISPATCH:
            begin
                if (!in_valid)
                    pc_next = UA_IDLE;
                else if (in_op == OP_START)
                    pc_next = UA_S0;
                else if (!status.active)
                    pc_next = UA_IDLE;
                else if (status.region_two)
                    pc_next = UA_U0;
                else
                    pc_next = UA_T0;
            end
            default:    pc_next = UA_IDLE;
        endcase
        // hold the emit step while the output beat is still pending
        if (word.emit && !status.slot_free)
            pc_next = pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= UA_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule
`default_nettype wire

/* design/mer_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mer_datapath
// Shared multiplier, decision/offset registers, boundary compare and the
// output beat register, all steered by the current control word.
// ----------------------------------------------------------------------------
module mer_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mer_pkg::ctrl_t                 word,
    input  wire logic                           in_valid,
    input  wire logic                           in_op,
    input  wire logic [mer_pkg::IN_DATA_W-1:0]  in_data,
    output mer_pkg::status_t                    status,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [mer_pkg::OUT_DATA_W-1:0]      out_data,
    output logic                                out_last,
    output logic                                out_region
);
    import mer_pkg::*;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic        [RADIUS_BITS-1:0] a_reg, b_reg;
    logic signed [XY_W-1:0]       x_reg, y_reg, x_next, y_next;
    logic signed [DEC_W-1:0]      d_reg, d_next;
    logic        [SQ_W-1:0]       a2_reg, b2_reg;
    logic        [SUM2_W-1:0]     s_reg;
    logic signed [PROD_W-1:0]     a4_reg, t_reg, u_reg, v_reg;
    logic                         active_reg, active_next;
    logic                         r2_reg, r2_next;
    logic                         out_valid_reg;
    logic [OUT_DATA_W-1:0]        out_data_reg;
    logic                         out_last_reg, out_region_reg;

    logic signed [MUL_W-1:0]      ma, mb;
    logic signed [MUL_W-1:0]      a_ext, b_ext, a2_ext, b2_ext, s_ext, x_ext, y_ext, t_ext;
    logic signed [PROD_W-1:0]     prod;
    logic signed [DEC_W-1:0]      u_dec, v2_dec, t_dec, d_sum;
    logic signed [DEC_W-1:0]      a2_dec, b2_dec, a2q_dec, b2q_dec;
    logic                         accept, slot_free, fire, fits, last_val;
    logic [OUT_FIELDS_W-1:0]      fields;

    function automatic logic [OUT_W-1:0] coord(
        input logic signed [COORD_BITS-1:0] c,
        input logic signed [XY_W-1:0]       o,
        input logic                         sub
    );
        logic signed [SUM_W-1:0] cs;
        logic signed [SUM_W-1:0] os;
        logic signed [SUM_W-1:0] r;
        cs = SUM_W'(c);
        os = SUM_W'(o);
        r  = sub ? (cs - os) : (cs + os);
        return r[OUT_W-1:0];
    endfunction

    assign accept    = word.take && in_valid;
    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = word.emit && slot_free;
    assign fits      = (x_reg < 0) || (t_reg <= a4_reg);

    assign status.zero_rad   = (a_reg == '0) || (b_reg == '0);
    assign status.fits       = fits;
    assign status.slot_free  = slot_free;
    assign status.active     = active_reg;
    assign status.region_two = r2_reg;

    // multiplier operands
    assign a_ext  = signed'(MUL_W'(a_reg));
    assign b_ext  = signed'(MUL_W'(b_reg));
    assign a2_ext = signed'(MUL_W'(a2_reg));
    assign b2_ext = signed'(MUL_W'(b2_reg));
    assign s_ext  = signed'(MUL_W'(s_reg));
    assign x_ext  = MUL_W'(x_reg);
    assign y_ext  = MUL_W'(y_reg);
    assign t_ext  = t_reg[MUL_W-1:0];

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (word.mul)
            MUL_AA:   begin ma = a_ext;  mb = a_ext; end
            MUL_BB:   begin ma = b_ext;  mb = b_ext; end
            MUL_A2A2: begin ma = a2_ext; mb = a2_ext; end
            MUL_A2B:  begin ma = a2_ext; mb = b_ext; end
            MUL_B2A:  begin ma = b2_ext; mb = a_ext; end
            MUL_XX:   begin ma = x_ext;  mb = x_ext; end
            MUL_TS:   begin ma = t_ext;  mb = s_ext; end
            MUL_B2X:  begin ma = b2_ext; mb = (x_ext <<< 1) + MUL_W'(3); end
            MUL_A2Y:  begin ma = a2_ext; mb = y_ext - MUL_W'(1); end
            MUL_A2YP: begin ma = a2_ext; mb = (y_ext <<< 1) + MUL_W'(3); end
            MUL_B2XM: begin ma = b2_ext; mb = x_ext - MUL_W'(1); end
            default:  begin ma = '0;     mb = '0; end
        endcase
    end

    assign prod = PROD_W'(ma) * PROD_W'(mb);

    // decision terms
    assign u_dec   = DEC_W'(u_reg);
    assign v2_dec  = DEC_W'(v_reg) <<< 1;
    assign t_dec   = DEC_W'(t_reg);
    assign a2_dec  = signed'(DEC_W'(a2_reg));
    assign b2_dec  = signed'(DEC_W'(b2_reg));
    assign a2q_dec = signed'(DEC_W'(a2_reg >> 2));
    assign b2q_dec = signed'(DEC_W'(b2_reg >> 2));
    assign d_sum   = d_reg + u_dec;

    always_comb
    begin
        case (word.last_sel)
            LAST_NO:  last_val = 1'b0;
            LAST_YES: last_val = 1'b1;
            LAST_FIT: last_val = fits;
            default:  last_val = 1'b0;
        endcase
    end

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        r2_next     = r2_reg;
        active_next = active_reg;
        case (word.act)
            ACT_INIT1:
            begin
                x_next      = '0;
                y_next      = signed'(XY_W'(b_reg));
                d_next      = b2_dec - t_dec + a2q_dec;
                r2_next     = 1'b0;
                active_next = 1'b1;
            end
            ACT_ZERO:
            begin
                x_next      = '0;
                y_next      = '0;
                d_next      = '0;
                r2_next     = 1'b0;
                active_next = 1'b0;
            end
            ACT_ENTER2:
            begin
                x_next  = signed'(XY_W'(a_reg));
                y_next  = '0;
                r2_next = 1'b1;
            end
            ACT_INIT2: d_next = a2_dec - t_dec + b2q_dec;
            ACT_UPD1:
            begin
                x_next = x_reg + XY_W'(1);
                if (d_reg < 0)
                    d_next = d_sum;
                else
                begin
                    d_next = d_sum - v2_dec;
                    y_next = y_reg - XY_W'(1);
                end
            end
            ACT_UPD2:
            begin
                y_next = y_reg + XY_W'(1);
                if (d_reg < 0)
                    d_next = d_sum;
                else
                begin
                    d_next = d_sum - v2_dec;
                    x_next = x_reg - XY_W'(1);
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
        if (fire && last_val)
            active_next = 1'b0;
    end

    assign fields = {coord(cy_reg, y_reg, 1'b0), coord(cx_reg, x_reg, 1'b1),
                     coord(cy_reg, y_reg, 1'b1), coord(cx_reg, x_reg, 1'b1),
                     coord(cy_reg, y_reg, 1'b1), coord(cx_reg, x_reg, 1'b0),
                     coord(cy_reg, y_reg, 1'b0), coord(cx_reg, x_reg, 1'b0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            r2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            r2_reg     <= r2_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_START)
        begin
            cx_reg <= signed'(in_data[COORD_BITS-1:0]);
            cy_reg <= signed'(in_data[2*COORD_BITS-1:COORD_BITS]);
            a_reg  <= in_data[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
            b_reg  <= in_data[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];
        end
        x_reg <= x_next;
        y_reg <= y_next;
        d_reg <= d_next;
        if (word.act == ACT_SUM)
            s_reg <= SUM2_W'(a2_reg) + SUM2_W'(b2_reg);
        case (word.mul)
            MUL_AA:   a2_reg <= prod[SQ_W-1:0];
            MUL_BB:   b2_reg <= prod[SQ_W-1:0];
            MUL_A2A2: a4_reg <= prod;
            MUL_A2B, MUL_B2A, MUL_XX, MUL_TS: t_reg <= prod;
            MUL_B2X, MUL_A2YP: u_reg <= prod;
            MUL_A2Y, MUL_B2XM: v_reg <= prod;
            default:  t_reg <= t_reg;
        endcase
        if (fire)
        begin
            out_data_reg   <= OUT_DATA_W'(fields);
            out_last_reg   <= last_val;
            out_region_reg <= r2_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;
    assign out_region = out_region_reg;

endmodule
`default_nettype wire

/* design/midpoint_ellipse_rasterizer_core.sv */
`default_nettype none
// A start beat runs S0 to S4 and EM0, or S0, ZRO and EM1 with a zero radius. A region
// one step runs T0 to T4 and EM0; one that crosses into region two runs T0 to T2, E0,
// E1 and C0 to C2; a region two step runs U0 to U2 and C0 to C2; a step while idle
// returns to the wait step. The microcode walks one beat at a time through the single
// shared multiplier; a stalled output beat holds the emit step and adds its wait.
// Reset: sequencer at its wait step, no ellipse active, output register empty.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Microcoded midpoint ellipse rasterizer: each start beat, and each step beat while an
// ellipse is active, yields one four-quadrant point set of an axis-aligned ellipse.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // center_x, center_y, radius_a, radius_b, zero pad
    input  wire logic [mer_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // q1_x, q1_y, q4_x, q4_y, q3_x, q3_y, q2_x, q2_y
    output logic [mer_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast,
    // region
    output logic [0:0]                             m_axis_tuser
);
    import mer_pkg::*;

    ctrl_t   word;
    status_t status;
    logic    out_region;

    mer_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser[0]),
        .status   (status),
        .word     (word)
    );

    mer_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .in_valid   (s_axis_tvalid),
        .in_op      (s_axis_tuser[0]),
        .in_data    (s_axis_tdata),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_region (out_region)
    );

    assign s_axis_tready   = word.take;
    assign m_axis_tuser[0] = out_region;

`ifndef SYNTHESIS
    // a step with no ellipse running returns straight to the wait step
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !status.active)
        |=> s_axis_tready)
        else $error("idle step did not return to wait");

    // a final point set always closes the ellipse
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_axis_tvalid) && m_axis_tlast) |-> !status.active)
        else $error("ellipse still active after final point set");

    // the only final set in region one is the zero radius set at the center
    a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0]) |->
        ((m_axis_tdata[OUT_W-1:0] == m_axis_tdata[5*OUT_W-1:4*OUT_W]) &&
         (m_axis_tdata[2*OUT_W-1:OUT_W] == m_axis_tdata[4*OUT_W-1:3*OUT_W])))
        else $error("region one final set not at center");
`endif

endmodule
`default_nettype wire
